FILE: src/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int QDIV_W = 16;
    localparam logic [QDIV_W-1:0] QDIV_RESET = 16'd62;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // command codes carried in the mode field
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       nak;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       sda_low;
        logic       scl_low;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       cmd_done;
        logic       read_done;
    } t_out_item;

endpackage

FILE: src/i2cmbe_regs.sv
// ----------------------------------------------------------------------------
// i2cmbe_regs
// APB configuration register: ticks per quarter bit.
// ----------------------------------------------------------------------------
module i2cmbe_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cmbe_pkg::PADDR_W-1:0]     paddr,
    input  logic [i2cmbe_pkg::PDATA_W-1:0]     pwdata,
    output logic [i2cmbe_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [i2cmbe_pkg::QDIV_W-1:0]      o_quarter_div
);

    localparam logic REG_QUARTER_DIV = 1'b0;

    logic [i2cmbe_pkg::QDIV_W-1:0] r_quarter_div;
    logic                          sel_qdiv;

    // registers sit on 4-byte boundaries; bit 2 is the register index
    assign sel_qdiv = (paddr[2] == REG_QUARTER_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter_div <= i2cmbe_pkg::QDIV_RESET;
        end else if (psel && penable && pwrite && sel_qdiv) begin
            r_quarter_div <= pwdata[i2cmbe_pkg::QDIV_W-1:0];
        end
    end

    assign prdata = sel_qdiv
        ? {{(i2cmbe_pkg::PDATA_W-i2cmbe_pkg::QDIV_W){1'b0}}, r_quarter_div}
        : '0;
    assign pready        = 1'b1;
    assign o_quarter_div = r_quarter_div;

endmodule

FILE: src/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// i2cmbe_core
// Bus sequencer state: advances one tick per item and forms its result.
// ----------------------------------------------------------------------------
module i2cmbe_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  i2cmbe_pkg::t_in_item          i_item,
    input  logic [i2cmbe_pkg::QDIV_W-1:0] i_quarter_div,
    output i2cmbe_pkg::t_out_item         o_result
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_STOP  = 3'd2,
        PH_WRITE = 3'd3,
        PH_READ  = 3'd4
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [3:0]                    r_bit, n_bit;
    logic [1:0]                    r_q, n_q;
    logic [i2cmbe_pkg::QDIV_W-1:0] r_pre, n_pre;
    logic [7:0]                    r_shift, n_shift;
    logic                          r_nak, n_nak;
    logic                          r_sda, n_sda;
    logic                          r_scl, n_scl;
    logic [7:0]                    r_last, n_last;

    logic [i2cmbe_pkg::QDIV_W-1:0] div;
    logic                          quarter_end;
    logic                          last;
    logic                          done;
    logic                          rdone;
    logic                          cmd_valid;

    // drives applied on entry to a quarter; returns {sda, scl}
    function automatic logic [1:0] f_enter(t_phase ph, logic [1:0] q, logic [3:0] b,
                                           logic [7:0] sh, logic nk, logic sda,
                                           logic scl);
        logic s;
        logic c;
        s = sda;
        c = scl;
        unique case (ph)
            PH_START: begin
                if (q == 2'd0) begin
                    s = 1'b0;
                    c = 1'b0;
                end else if (q == 2'd1) begin
                    s = 1'b1;
                end else begin
                    c = 1'b1;
                end
            end
            PH_STOP: begin
                if (q == 2'd0) begin
                    s = 1'b1;
                    c = 1'b1;
                end else if (q == 2'd1) begin
                    c = 1'b0;
                end else begin
                    s = 1'b0;
                end
            end
            PH_WRITE, PH_READ: begin
                if (q == 2'd0) begin
                    if (b < 4'd8) begin
                        s = (ph == PH_WRITE) ? ~sh[7] : 1'b0;
                    end else begin
                        s = (ph == PH_WRITE) ? 1'b0 : ~nk;
                    end
                end else if (q == 2'd1) begin
                    c = 1'b0;
                end else if (q == 2'd3) begin
                    c = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return {s, c};
    endfunction

    assign div = (i_quarter_div == '0) ? {{(i2cmbe_pkg::QDIV_W-1){1'b0}}, 1'b1}
                                       : i_quarter_div;
    assign quarter_end = ({1'b0, r_pre} + {{i2cmbe_pkg::QDIV_W{1'b0}}, 1'b1})
                         >= {1'b0, div};
    assign cmd_valid = (i_item.mode == i2cmbe_pkg::MODE_START)
                    || (i_item.mode == i2cmbe_pkg::MODE_STOP)
                    || (i_item.mode == i2cmbe_pkg::MODE_WRITE)
                    || (i_item.mode == i2cmbe_pkg::MODE_READ);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_q     = r_q;
        n_pre   = r_pre;
        n_shift = r_shift;
        n_nak   = r_nak;
        n_sda   = r_sda;
        n_scl   = r_scl;
        n_last  = r_last;
        last    = 1'b0;
        done    = 1'b0;
        rdone   = 1'b0;
        if (r_phase == PH_IDLE) begin
            if (cmd_valid) begin
                n_phase = t_phase'(i_item.mode);
                n_bit   = 4'd0;
                n_q     = 2'd0;
                n_pre   = '0;
                if (i_item.mode == i2cmbe_pkg::MODE_WRITE) begin
                    n_shift = i_item.data_byte;
                end
                if (i_item.mode == i2cmbe_pkg::MODE_READ) begin
                    n_shift = 8'd0;
                    n_nak   = i_item.nak;
                end
                {n_sda, n_scl} = f_enter(n_phase, 2'd0, 4'd0, n_shift, n_nak,
                                         r_sda, r_scl);
            end
        end else if (quarter_end) begin
            n_pre = '0;
            // read samples at the end of quarter 1, write shifts after quarter 3
            if (r_phase == PH_READ && r_q == 2'd1 && r_bit < 4'd8) begin
                n_shift = {r_shift[6:0], i_item.sda_in};
            end
            if (r_phase == PH_WRITE && r_q == 2'd3 && r_bit < 4'd8) begin
                n_shift = {r_shift[6:0], 1'b0};
            end
            if (r_phase == PH_START || r_phase == PH_STOP) begin
                last = (r_q >= 2'd2);
                n_q  = r_q + 2'd1;
            end else begin
                last = (r_q == 2'd3) && (r_bit >= 4'd8);
                n_q  = r_q + 2'd1;
                if (r_q == 2'd3) begin
                    n_bit = r_bit + 4'd1;
                end
            end
            if (!last) begin
                {n_sda, n_scl} = f_enter(r_phase, n_q, n_bit, n_shift, r_nak,
                                         r_sda, r_scl);
            end else begin
                if (r_phase == PH_READ) begin
                    n_last = n_shift;
                    n_sda  = 1'b0;
                    rdone  = 1'b1;
                end
                done    = 1'b1;
                n_phase = PH_IDLE;
                n_bit   = 4'd0;
                n_q     = 2'd0;
            end
        end else begin
            n_pre = r_pre + {{(i2cmbe_pkg::QDIV_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= 4'd0;
            r_q     <= 2'd0;
            r_pre   <= '0;
            r_shift <= 8'd0;
            r_nak   <= 1'b0;
            r_sda   <= 1'b0;
            r_scl   <= 1'b0;
            r_last  <= 8'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_q     <= n_q;
            r_pre   <= n_pre;
            r_shift <= n_shift;
            r_nak   <= n_nak;
            r_sda   <= n_sda;
            r_scl   <= n_scl;
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_result.sda_low   = n_sda;
        o_result.scl_low   = n_scl;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.read_byte = n_last;
        o_result.cmd_done  = done;
        o_result.read_done = rdone;
    end

endmodule

FILE: src/i2c_master_bit_engine_unit.sv
// Each tick item passes the input register, then the result register.
// Throughput: one item per cycle while results are taken; the result register
// frees itself when taken.
// Reset (i_rst_n low, synchronous): bus idle, SDA and SCL released,
// read byte 0, quarter_div back to 62, both registers emptied.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine: one tick item in, one pin/status item out.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  i2cmbe_pkg::t_in_item               i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output i2cmbe_pkg::t_out_item              o_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cmbe_pkg::PADDR_W-1:0]     paddr,
    input  logic [i2cmbe_pkg::PDATA_W-1:0]     pwdata,
    output logic [i2cmbe_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready
);

    logic                          r_in_valid;
    i2cmbe_pkg::t_in_item          r_in_item;
    logic                          r_out_valid;
    i2cmbe_pkg::t_out_item         r_out_item;
    logic                          adv;
    logic [i2cmbe_pkg::QDIV_W-1:0] quarter_div;
    i2cmbe_pkg::t_out_item         result;

    // the held item moves on whenever the result register is free or being taken
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    i2cmbe_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_quarter_div (quarter_div)
    );

    i2cmbe_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_item        (r_in_item),
        .i_quarter_div (quarter_div),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: sim/i2cmbe_tb_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_tb_pkg
// Register map of the bit engine as seen from the test bench.
// ----------------------------------------------------------------------------
package i2cmbe_tb_pkg;

    localparam logic [i2cmbe_pkg::PADDR_W-1:0] QDIV_ADDR  = i2cmbe_pkg::PADDR_W'(0);
    // one word past the last register, decodes to nothing
    localparam logic [i2cmbe_pkg::PADDR_W-1:0] SPARE_ADDR = i2cmbe_pkg::PADDR_W'(4);

endpackage

FILE: sim/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Watches the tick and result channels and the register port of the bit
// engine, runs its own copy of the engine on every accepted tick and compares
// each accepted result field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  i2cmbe_pkg::t_in_item               i_in_item,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  i2cmbe_pkg::t_out_item              i_out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cmbe_pkg::PADDR_W-1:0]     paddr,
    input  logic [i2cmbe_pkg::PDATA_W-1:0]     pwdata,
    input  logic [i2cmbe_pkg::PDATA_W-1:0]     prdata,
    input  logic                               pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import i2cmbe_pkg::*;
    import i2cmbe_tb_pkg::*;

    logic [QDIV_W-1:0] quarter_ticks;
    logic [2:0]        phase;       // MODE_NONE while idle
    logic [3:0]        bit_pos;
    logic [1:0]        quarter;
    logic [QDIV_W-1:0] prescale;
    logic [7:0]        shifter;
    logic              nak_hold;
    logic              sda_pull;
    logic              scl_pull;
    logic [7:0]        read_hold;

    t_out_item expected_pins[$];
    int        fails = 0;

    task automatic compare_field(input string name, input logic [PDATA_W-1:0] want,
                                 input logic [PDATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // pin drives at the start of the current quarter
    task automatic open_quarter();
        case (phase)
            MODE_START: begin
                if (quarter == 2'd0) begin
                    sda_pull = 1'b0;
                    scl_pull = 1'b0;
                end else if (quarter == 2'd1) begin
                    sda_pull = 1'b1;
                end else begin
                    scl_pull = 1'b1;
                end
            end
            MODE_STOP: begin
                if (quarter == 2'd0) begin
                    sda_pull = 1'b1;
                    scl_pull = 1'b1;
                end else if (quarter == 2'd1) begin
                    scl_pull = 1'b0;
                end else begin
                    sda_pull = 1'b0;
                end
            end
            MODE_WRITE, MODE_READ: begin
                if (quarter == 2'd0) begin
                    if (bit_pos < 4'd8)
                        sda_pull = (phase == MODE_WRITE) ? ~shifter[7] : 1'b0;
                    else
                        sda_pull = (phase == MODE_WRITE) ? 1'b0 : ~nak_hold;
                end else if (quarter == 2'd1) begin
                    scl_pull = 1'b0;
                end else if (quarter == 2'd3) begin
                    scl_pull = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic close_quarter(input logic sda, output logic finished);
        if (phase == MODE_READ && quarter == 2'd1 && bit_pos < 4'd8)
            shifter = {shifter[6:0], sda};
        if (phase == MODE_WRITE && quarter == 2'd3 && bit_pos < 4'd8)
            shifter = {shifter[6:0], 1'b0};
        if (phase == MODE_START || phase == MODE_STOP) begin
            finished = (quarter >= 2'd2);
            quarter  = quarter + 2'd1;
        end else begin
            finished = (quarter == 2'd3 && bit_pos >= 4'd8);
            if (quarter == 2'd3)
                bit_pos = bit_pos + 4'd1;
            quarter = quarter + 2'd1;
        end
        if (!finished)
            open_quarter();
    endtask

    task automatic step_bus_engine(input t_in_item tick, output t_out_item pins);
        logic [QDIV_W:0] div;
        logic            finished;
        logic            done;
        logic            rdone;
        done  = 1'b0;
        rdone = 1'b0;
        div   = (quarter_ticks == '0) ? (QDIV_W+1)'(1) : {1'b0, quarter_ticks};
        if (phase == MODE_NONE) begin
            if (tick.mode >= MODE_START && tick.mode <= MODE_READ) begin
                phase    = tick.mode;
                bit_pos  = '0;
                quarter  = '0;
                prescale = '0;
                if (tick.mode == MODE_WRITE)
                    shifter = tick.data_byte;
                if (tick.mode == MODE_READ) begin
                    shifter  = '0;
                    nak_hold = tick.nak;
                end
                open_quarter();
            end
        end else if ({1'b0, prescale} + (QDIV_W+1)'(1) >= div) begin
            prescale = '0;
            close_quarter(tick.sda_in, finished);
            if (finished) begin
                if (phase == MODE_READ) begin
                    read_hold = shifter;
                    sda_pull  = 1'b0;
                    rdone     = 1'b1;
                end
                done    = 1'b1;
                phase   = MODE_NONE;
                bit_pos = '0;
                quarter = '0;
            end
        end else begin
            prescale = prescale + 1'b1;
        end
        pins.sda_low   = sda_pull;
        pins.scl_low   = scl_pull;
        pins.busy_res  = (phase != MODE_NONE);
        pins.read_byte = read_hold;
        pins.cmd_done  = done;
        pins.read_done = rdone;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            quarter_ticks = QDIV_RESET;
            phase         = MODE_NONE;
            bit_pos       = '0;
            quarter       = '0;
            prescale      = '0;
            shifter       = '0;
            nak_hold      = 1'b0;
            sda_pull      = 1'b0;
            scl_pull      = 1'b0;
            read_hold     = '0;
            expected_pins.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t: result with no item outstanding, actual %h",
                             $time, i_out_item);
                    fails++;
                end else begin
                    want = expected_pins.pop_front();
                    compare_field("sda_low", PDATA_W'(want.sda_low),
                                  PDATA_W'(i_out_item.sda_low));
                    compare_field("scl_low", PDATA_W'(want.scl_low),
                                  PDATA_W'(i_out_item.scl_low));
                    compare_field("busy_res", PDATA_W'(want.busy_res),
                                  PDATA_W'(i_out_item.busy_res));
                    compare_field("read_byte", PDATA_W'(want.read_byte),
                                  PDATA_W'(i_out_item.read_byte));
                    compare_field("cmd_done", PDATA_W'(want.cmd_done),
                                  PDATA_W'(i_out_item.cmd_done));
                    compare_field("read_done", PDATA_W'(want.read_done),
                                  PDATA_W'(i_out_item.read_done));
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_bus_engine(i_in_item, want);
                expected_pins.push_back(want);
            end
            if (psel && penable && pready && paddr == QDIV_ADDR) begin
                if (pwrite)
                    quarter_ticks = pwdata[QDIV_W-1:0];
                else
                    compare_field("quarter_div readback",
                                  {{(PDATA_W-QDIV_W){1'b0}}, quarter_ticks}, prdata);
            end
        end
        o_pending    = expected_pins.size();
        o_fail_count = fails;
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the I2C bit engine with bus ticks: directed commands at the divider
// extremes first, then random command sequences with random pad levels,
// random gaps on both channels and divider changes between sequences.
// ----------------------------------------------------------------------------
module testbench;
    import i2cmbe_pkg::*;
    import i2cmbe_tb_pkg::*;

    localparam int RAND_TICKS      = 740;
    localparam int LIMIT_CYCLES    = 1_500_000;
    localparam int SHORT_QUARTERS  = 3;     // start, stop
    localparam int BYTE_QUARTERS   = 36;    // 8 data bits plus ack
    localparam int WIDE_TICKS      = 20;
    localparam logic [2:0] MODE_FIRST_BAD = 3'd5;
    localparam logic [2:0] MODE_LAST_BAD  = 3'd7;

    typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} t_sda_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    bit                   calm = 1'b0;
    int                   cur_div;
    int                   ticks_sent;

    i2c_master_bit_engine_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    i2cmbe_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 15);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_in_item make_tick(input logic [2:0] mode, input t_sda_kind kind);
        t_in_item tick;
        tick.mode      = mode;
        tick.data_byte = 8'($urandom_range(0, 255));
        tick.nak       = 1'($urandom_range(0, 1));
        case (kind)
            SDA_LOW:  tick.sda_in = 1'b0;
            SDA_HIGH: tick.sda_in = 1'b1;
            default:  tick.sda_in = 1'($urandom_range(0, 1));
        endcase
        return tick;
    endfunction

    task automatic push_tick(input t_in_item tick);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= tick;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // ticks while the engine is busy; noise_pct of them carry a random mode
    task automatic bus_wait(input int n, input t_sda_kind kind, input int noise_pct);
        logic [2:0] mode;
        repeat (n) begin
            mode = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : MODE_NONE;
            push_tick(make_tick(mode, kind));
        end
    endtask

    // one command from idle, followed by exactly the ticks it keeps the engine busy
    task automatic issue(input logic [2:0] mode, input logic [7:0] data, input logic nak,
                         input t_sda_kind kind, input int noise_pct);
        t_in_item tick;
        int       quarters;
        tick           = make_tick(mode, kind);
        tick.data_byte = data;
        tick.nak       = nak;
        push_tick(tick);
        quarters = (mode == MODE_WRITE || mode == MODE_READ) ? BYTE_QUARTERS : SHORT_QUARTERS;
        bus_wait(quarters * cur_div, kind, noise_pct);
    endtask

    task automatic idle_noise(input int n);
        logic [2:0] mode;
        repeat (n) begin
            mode = $urandom_range(0, 1) ? MODE_NONE
                                        : 3'($urandom_range(MODE_FIRST_BAD, MODE_LAST_BAD));
            push_tick(make_tick(mode, SDA_RANDOM));
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic reg_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (is_write && addr == QDIV_ADDR)
            cur_div = (data[QDIV_W-1:0] == '0) ? 1 : int'(data[QDIV_W-1:0]);
    endtask

    initial begin
        int         base;
        logic [2:0] op;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cur_div    = int'(QDIV_RESET);
        ticks_sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset divider
        reg_access(1'b0, QDIV_ADDR, '0);
        issue(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

        drain();
        reg_access(1'b1, QDIV_ADDR, 32'd1);
        issue(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_WRITE, 8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_WRITE, 8'hFF, 1'b1, SDA_RANDOM, 0);
        issue(MODE_READ, 8'h00, 1'b0, SDA_HIGH, 0);
        issue(MODE_READ, 8'hFF, 1'b1, SDA_LOW, 0);
        // every tick after the command carries a random mode that must be ignored
        issue(MODE_WRITE, 8'h5A, 1'b1, SDA_RANDOM, 100);
        for (int m = MODE_FIRST_BAD; m <= MODE_LAST_BAD; m++)
            push_tick(make_tick(3'(m), SDA_RANDOM));
        issue(MODE_STOP, 8'hFF, 1'b1, SDA_RANDOM, 0);

        // zero divider acts as one
        drain();
        reg_access(1'b1, QDIV_ADDR, 32'd0);
        reg_access(1'b0, QDIV_ADDR, '0);
        issue(MODE_READ, 8'h00, 1'b0, SDA_RANDOM, 10);

        // upper write bits are dropped
        drain();
        reg_access(1'b1, QDIV_ADDR, 32'hABCD_0002);
        reg_access(1'b0, QDIV_ADDR, '0);
        issue(MODE_WRITE, 8'hC3, 1'b0, SDA_RANDOM, 10);

        // write to an unmapped word leaves the divider alone
        drain();
        reg_access(1'b1, SPARE_ADDR, 32'd9);
        reg_access(1'b0, QDIV_ADDR, '0);
        issue(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 10);

        // widest divider: a start is begun under it, then the divider drops to one
        // so the remaining quarters finish one tick each
        drain();
        reg_access(1'b1, QDIV_ADDR, 32'h0000_FFFF);
        reg_access(1'b0, QDIV_ADDR, '0);
        push_tick(make_tick(MODE_START, SDA_RANDOM));
        bus_wait(WIDE_TICKS, SDA_RANDOM, 5);

        drain();
        reg_access(1'b1, QDIV_ADDR, 32'd1);
        bus_wait(SHORT_QUARTERS, SDA_RANDOM, 0);
        base = ticks_sent;
        while (ticks_sent - base < RAND_TICKS) begin
            calm = (ticks_sent - base >= 250) && (ticks_sent - base < 500);
            if ($urandom_range(0, 99) < 8) begin
                drain();
                if ($urandom_range(0, 99) < 60)
                    reg_access(1'b1, QDIV_ADDR, 32'($urandom_range(0, 4)));
            end
            if ($urandom_range(0, 99) < 85) begin
                op = 3'($urandom_range(MODE_START, MODE_READ));
                issue(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM, 10);
            end else begin
                idle_noise($urandom_range(1, 4));
            end
        end
        calm = 1'b0;

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
